// File: src/assert_macros.svh
// Assertion macros shared by the RTL. They turn into nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every rising edge outside reset.
`define AST_HOLD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must never be true outside reset.
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AST_HOLD(lbl, clk, rst_n, prop, msg)
`define AST_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: src/hite_pkg.sv
package hite_pkg;

  // Table geometry and field widths.
  localparam int TBL_DEPTH = 64;
  localparam int IDX_W = $clog2(TBL_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int HASH_W = 32;
  localparam int ID_W = 16;
  localparam int HITS_W = 32;

  // Operation codes.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_WIPE = 3'd2;
  localparam logic [2:0] OP_SORT = 3'd3;
  localparam logic [2:0] OP_CHOMP = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [ID_W-1:0]   owner;
    logic [HITS_W-1:0] hits;
  } entry_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key_hash;
    logic [15:0] entry_id;
    logic [5:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [31:0] hit_count;
    logic [6:0]  entry_count;
  } out_word_t;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_HASH_GT,
    CMP_RANK_LT
  } cmp_mode_t;

endpackage

// File: src/hash_id_table_engine.sv
// Add, wipe, unknown operations and a sort or chomp with no work answer in the next cycle.
// Lookup reads and then compares each entry in turn, as the table has one read port.
// Sort runs an insertion sort, ascending by hash, then a scan for leading empty entries
// and a compaction that copies the remaining entries down to the front.
// Chomp runs two such sorts and a clearing pass between them; one word at a time.
// Synchronous reset empties the table by zeroing its entry count; results cannot be stalled.
`include "assert_macros.svh"
module hash_id_table_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hite_pkg::in_word_t  in_word,
  output logic                out_valid,
  output hite_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);
  import hite_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LK_RD, S_LK_CMP, S_LDCUR, S_GETCUR, S_RDPREV, S_CMP, S_PUT,
    S_CLR, S_LEAD_RD, S_LEAD_CHK, S_CP_RD, S_CP_WR
  } state_t;

  state_t    state_r, state_nxt;
  in_word_t  req_r, req_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [6:0] max_r, max_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, lead_r, lead_nxt;
  entry_t    cur_r, cur_nxt;
  logic      by_hits_r, by_hits_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, rd;
  cmp_mode_t        cmp_mode;
  entry_t           cmp_b;
  logic             cmp_hit;
  logic [CNT_W-1:0] cap, jm1, src, i_inc;
  logic [HITS_W-1:0] hits_inc;

  hite_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rd)
  );

  hite_cmp u_cmp (.mode(cmp_mode), .a(rd), .b(cmp_b), .hit(cmp_hit));

  // Effective capacity and small helper values.
  assign cap = (max_r == '0 || max_r > 7'(TBL_DEPTH)) ? CNT_W'(TBL_DEPTH) : CNT_W'(max_r);
  assign jm1 = j_r - CNT_W'(1);
  assign src = i_r + lead_r;
  assign i_inc = i_r + CNT_W'(1);
  assign hits_inc = (rd.hits == '1) ? rd.hits : rd.hits + HITS_W'(1);

  // Shared compare unit: equality for lookup, otherwise the sort order.
  always_comb begin
    cmp_b = cur_r;
    if (state_r == S_LK_CMP) begin
      cmp_mode = CMP_EQ;
      cmp_b.hash = req_r.key_hash;
    end else if (by_hits_r) begin
      cmp_mode = CMP_RANK_LT;
    end else begin
      cmp_mode = CMP_HASH_GT;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    used_nxt = used_r;
    max_nxt = cfg_we ? cfg_wdata : max_r;
    i_nxt = i_r;
    j_nxt = j_r;
    lead_nxt = lead_r;
    cur_nxt = cur_r;
    by_hits_nxt = by_hits_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    mem_we = 1'b0;
    mem_waddr = i_r[IDX_W-1:0];
    mem_wdata = '0;
    mem_raddr = i_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_word;
          out_nxt.status = ST_OK;
          out_nxt.found_index = '0;
          out_nxt.hit_count = '0;
          case (in_word.operation)
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (used_r >= cap) begin
                out_nxt.status = ST_RANGE;
              end else begin
                mem_we = 1'b1;
                mem_waddr = used_r[IDX_W-1:0];
                mem_wdata.hash = in_word.key_hash;
                mem_wdata.owner = in_word.entry_id;
                used_nxt = used_r + CNT_W'(1);
              end
            end
            OP_LOOKUP: begin
              if (used_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt.status = ST_NOT_FOUND;
              end else begin
                i_nxt = '0;
                state_nxt = S_LK_RD;
              end
            end
            OP_WIPE: begin
              out_valid_nxt = 1'b1;
              if (CNT_W'(in_word.entry_index) >= used_r) begin
                out_nxt.status = ST_RANGE;
              end else begin
                mem_we = 1'b1;
                mem_waddr = in_word.entry_index[IDX_W-1:0];
              end
            end
            OP_SORT: begin
              if (used_r < CNT_W'(2)) begin
                out_valid_nxt = 1'b1;
              end else begin
                by_hits_nxt = 1'b0;
                i_nxt = CNT_W'(1);
                state_nxt = S_LDCUR;
              end
            end
            OP_CHOMP: begin
              if (used_r >= CNT_W'(2) && used_r >= (cap >> 1)) begin
                by_hits_nxt = 1'b1;
                i_nxt = CNT_W'(1);
                state_nxt = S_LDCUR;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt.status = ST_RANGE;
            end
          endcase
        end
      end
      S_LK_RD: begin
        state_nxt = S_LK_CMP;
      end
      S_LK_CMP: begin
        if (cmp_hit) begin
          mem_we = 1'b1;
          mem_wdata = rd;
          mem_wdata.hits = hits_inc;
          out_valid_nxt = 1'b1;
          out_nxt.found_index = 6'(i_r);
          out_nxt.hit_count = hits_inc;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_inc;
          if (i_inc == used_r) begin
            out_valid_nxt = 1'b1;
            out_nxt.status = ST_NOT_FOUND;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LK_RD;
          end
        end
      end
      S_LDCUR: begin
        state_nxt = S_GETCUR;
      end
      S_GETCUR: begin
        cur_nxt = rd;
        j_nxt = i_r;
        state_nxt = S_RDPREV;
      end
      S_RDPREV: begin
        mem_raddr = jm1[IDX_W-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cmp_hit) begin
          mem_we = 1'b1;
          mem_waddr = j_r[IDX_W-1:0];
          mem_wdata = rd;
          j_nxt = jm1;
          state_nxt = (jm1 == '0) ? S_PUT : S_RDPREV;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        mem_waddr = j_r[IDX_W-1:0];
        mem_wdata = cur_r;
        i_nxt = i_inc;
        if (i_inc == used_r) begin
          if (by_hits_r) begin
            i_nxt = used_r >> 1;
            state_nxt = S_CLR;
          end else begin
            lead_nxt = '0;
            state_nxt = S_LEAD_RD;
          end
        end else begin
          state_nxt = S_LDCUR;
        end
      end
      S_CLR: begin
        // Drop the less-hit half, then run the hash sort.
        mem_we = 1'b1;
        i_nxt = i_inc;
        if (i_inc == used_r) begin
          by_hits_nxt = 1'b0;
          i_nxt = CNT_W'(1);
          state_nxt = S_LDCUR;
        end
      end
      S_LEAD_RD: begin
        mem_raddr = lead_r[IDX_W-1:0];
        state_nxt = S_LEAD_CHK;
      end
      S_LEAD_CHK: begin
        if (rd.owner == '0) begin
          lead_nxt = lead_r + CNT_W'(1);
          if (lead_nxt == used_r) begin
            out_valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LEAD_RD;
          end
        end else if (lead_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = '0;
          state_nxt = S_CP_RD;
        end
      end
      S_CP_RD: begin
        mem_raddr = src[IDX_W-1:0];
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        mem_we = 1'b1;
        mem_wdata = rd;
        i_nxt = i_inc;
        if (src + CNT_W'(1) == used_r) begin
          used_nxt = used_r - lead_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_nxt.entry_count = 7'(used_nxt);
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      max_r <= '0;
      by_hits_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      max_r <= max_nxt;
      by_hits_r <= by_hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r <= req_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    lead_r <= lead_nxt;
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_r;

  `AST_HOLD(a_strobe_idle, clk, rst_n, out_valid_r |-> state_r == S_IDLE, "result while busy")
  `AST_NEVER(a_used_cap, clk, rst_n, used_r > CNT_W'(TBL_DEPTH), "entry count past depth")
  `AST_HOLD(a_miss_zero, clk, rst_n, (out_valid_r && out_r.status != ST_OK) |-> (out_r.hit_count == '0 && out_r.found_index == '0), "failed result carries data")
endmodule

// File: src/hite_mem.sv
module hite_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [hite_pkg::IDX_W-1:0] waddr,
  input  hite_pkg::entry_t          wdata,
  input  logic [hite_pkg::IDX_W-1:0] raddr,
  output hite_pkg::entry_t          rdata
);
  import hite_pkg::*;

  entry_t mem [TBL_DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/hite_cmp.sv
module hite_cmp (
  input  hite_pkg::cmp_mode_t mode,
  input  hite_pkg::entry_t    a,
  input  hite_pkg::entry_t    b,
  output logic                hit
);
  import hite_pkg::*;

  logic [HITS_W:0] rank_a;
  logic [HITS_W:0] rank_b;

  // Empty entries rank lowest; others rank by hit count.
  assign rank_a = (a.owner != '0) ? ({1'b0, a.hits} + (HITS_W+1)'(1)) : '0;
  assign rank_b = (b.owner != '0) ? ({1'b0, b.hits} + (HITS_W+1)'(1)) : '0;

  always_comb begin
    unique case (mode)
      CMP_EQ:      hit = (a.hash == b.hash);
      CMP_HASH_GT: hit = (a.hash > b.hash);
      CMP_RANK_LT: hit = (rank_a < rank_b);
      default:     hit = 1'b0;
    endcase
  end
endmodule
